>>> src/nfd_pkg.sv
// package for the nfa to dfa subset construction core
// operation and result codes, default sizes and the result word type
// no dependencies
`default_nettype none

package nfd_pkg;

    // default sizes of the core
    localparam int NFA_STATES_DEF = 16;
    localparam int ALPHABET_DEF   = 32;
    localparam int DFA_STATES_DEF = 256;

    // input operation codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MARK  = 2'd1,
        OP_BEGIN = 2'd2,
        OP_STEP  = 2'd3
    } t_op;

    // result kinds
    typedef enum logic [1:0] {
        K_EDGE     = 2'd0,
        K_RECORD   = 2'd1,
        K_DONE     = 2'd2,
        K_OVERFLOW = 2'd3
    } t_kind;

    // one result word
    typedef struct packed {
        t_kind       kind;
        logic [15:0] from_set;
        logic [4:0]  edge_letter;
        logic [15:0] to_set;
        logic        accepting;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

>>> src/nfd_ifs.sv
// channel interfaces of the subset construction core: input, result, config
// valid/ready handshake, a word moves when both are high
// no dependencies
`default_nettype none

interface nfd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [3:0] from_state;
    logic [3:0] to_state;
    logic [4:0] letter;
    logic [3:0] terminal_index;
    modport source (output valid, operation, from_state, to_state, letter, terminal_index,
                    input ready);
    modport sink (input valid, operation, from_state, to_state, letter, terminal_index,
                  output ready);
endinterface

interface nfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] from_set;
    logic [4:0]  edge_letter;
    logic [15:0] to_set;
    logic        accepting;
    logic        last;
    modport source (output valid, kind, from_set, edge_letter, to_set, accepting, last,
                    input ready);
    modport sink (input valid, kind, from_set, edge_letter, to_set, accepting, last,
                  output ready);
endinterface

interface nfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> src/nfd_out_stage.sv
// result output register of the subset construction core
// holds one result word until the sink takes it
// depends on nfd_pkg and nfd_out_if
`default_nettype none

module nfd_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire nfd_pkg::t_result i_word,
    output logic                  o_free,
    nfd_out_if.source             o_out
);

    logic             r_valid;
    nfd_pkg::t_result r_word;

    assign o_free = !r_valid || o_out.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push && o_free) begin
            r_word <= i_word;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_word.kind;
    assign o_out.from_set    = r_word.from_set;
    assign o_out.edge_letter = r_word.edge_letter;
    assign o_out.to_set      = r_word.to_set;
    assign o_out.accepting   = r_word.accepting;
    assign o_out.last        = r_word.last;

endmodule

`default_nettype wire

>>> src/nfa_to_dfa_subset_construction_core.sv
// top level of the nfa to dfa subset construction core
// transition memory, discovered-set memory and the step sequencer
// depends on nfd_pkg, nfd_ifs and nfd_out_stage
//
//  port     dir  word
//  i_in     in   operation, from_state, to_state, letter, terminal_index
//  o_out    out  kind, from_set, edge_letter, to_set, accepting, last
//  i_cfg    in   start_state
//
// after reset a clearing pass writes all 2**(SB+LB) transition entries (512 at
// default sizes), while no input word is accepted.
// load reads the entry in idle and writes it back in S_LOAD_WR; mark and begin
// finish in idle. a step reads every nfa state for every letter from the
// transition memory and for each emitted edge scans the discovered list.
// one input word is worked at a time; a stalled output holds the sequencer.
`default_nettype none

module nfa_to_dfa_subset_construction_core #(
    parameter int NFA_STATES = nfd_pkg::NFA_STATES_DEF,
    parameter int ALPHABET   = nfd_pkg::ALPHABET_DEF,
    parameter int DFA_STATES = nfd_pkg::DFA_STATES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nfd_in_if.sink    i_in,
    nfd_out_if.source o_out,
    nfd_cfg_if.sink   i_cfg
);

    localparam int SW  = NFA_STATES;
    localparam int SB  = $clog2(NFA_STATES);
    localparam int LB  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int AB  = SB + LB;
    localparam int TD  = 2 ** AB;
    localparam int DB  = $clog2(DFA_STATES);
    localparam int DW  = DB + 1;
    localparam int SIW = SB + 1;
    localparam int LW  = LB + 1;

    localparam logic [SIW-1:0] C_NS   = SIW'(NFA_STATES);
    localparam logic [LW-1:0]  C_LAST = LW'(ALPHABET - 1);
    localparam logic [DW-1:0]  C_DFA  = DW'(DFA_STATES);
    localparam logic [AB:0]    C_TD   = (AB + 1)'(TD);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD_WR, S_CUR, S_ACC, S_DECIDE,
        S_EDGE, S_SRCH, S_APPEND, S_REC, S_DONE
    } t_state;

    t_state            r_st;
    logic [AB:0]       r_clr;
    logic [3:0]        r_start;
    logic [SW-1:0]     r_acc;
    logic [DW-1:0]     r_head;
    logic [DW-1:0]     r_dcount;
    logic [AB-1:0]     r_laddr;
    logic [SB-1:0]     r_ts;
    logic [SW-1:0]     r_cur;
    logic [SW-1:0]     r_tgt;
    logic [SIW-1:0]    r_si;
    logic [LW-1:0]     r_let;
    logic [DW-1:0]     r_sidx;
    logic              r_pend;
    logic              r_pmem;
    logic              r_found;
    logic              r_full;

    // memories
    logic [SW-1:0] tmem [TD];
    logic [SW-1:0] dmem [DFA_STATES];
    logic [SW-1:0] tm_q, dm_q, tm_wdata, dm_wdata;
    logic [AB-1:0] tm_raddr, tm_waddr;
    logic [DB-1:0] dm_raddr, dm_waddr;
    logic          tm_we, dm_we;

    logic             in_acc, out_free, push;
    nfd_pkg::t_result word;
    logic             edge_ok, mark_ok, start_ok, append;
    logic [SB-1:0]    fs_i, ts_i, ti_i;
    logic [LB-1:0]    lt_i;
    logic [SW+15:0]   cur_x, tgt_x;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_st == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;

    assign fs_i     = SB'(i_in.from_state);
    assign ts_i     = SB'(i_in.to_state);
    assign ti_i     = SB'(i_in.terminal_index);
    assign lt_i     = LB'(i_in.letter);
    assign edge_ok  = (32'(i_in.from_state) < NFA_STATES) && (32'(i_in.to_state) < NFA_STATES)
                      && (32'(i_in.letter) < ALPHABET);
    assign mark_ok  = 32'(i_in.terminal_index) < NFA_STATES;
    assign start_ok = 32'(r_start) < NFA_STATES;
    assign append   = (r_st == S_APPEND) && !r_found && (r_dcount < C_DFA);
    assign cur_x    = {16'b0, r_cur};
    assign tgt_x    = {16'b0, r_tgt};

    // memory port control
    always_comb begin
        tm_raddr = (r_st == S_IDLE) ? {fs_i, lt_i} : {r_si[SB-1:0], r_let[LB-1:0]};
        tm_we    = (r_st == S_CLEAR) || (r_st == S_LOAD_WR);
        tm_waddr = (r_st == S_CLEAR) ? r_clr[AB-1:0] : r_laddr;
        tm_wdata = (r_st == S_CLEAR) ? '0 : (tm_q | (SW'(1) << r_ts));
        dm_raddr = (r_st == S_SRCH) ? r_sidx[DB-1:0] : r_head[DB-1:0];
        dm_we    = append || (in_acc && i_in.operation == nfd_pkg::OP_BEGIN && start_ok);
        dm_waddr = append ? r_dcount[DB-1:0] : '0;
        dm_wdata = append ? r_tgt : (SW'(1) << SB'(r_start));
    end

    always_ff @(posedge i_clk) begin
        if (tm_we) begin
            tmem[tm_waddr] <= tm_wdata;
        end
        tm_q <= tmem[tm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dmem[dm_waddr] <= dm_wdata;
        end
        dm_q <= dmem[dm_raddr];
    end

    // result word selection
    always_comb begin
        push = 1'b0;
        word = '0;
        case (r_st)
            S_EDGE: begin
                push             = 1'b1;
                word.kind        = nfd_pkg::K_EDGE;
                word.from_set    = cur_x[15:0];
                word.edge_letter = 5'(r_let);
                word.to_set      = tgt_x[15:0];
            end
            S_REC: begin
                push           = 1'b1;
                word.kind      = r_full ? nfd_pkg::K_OVERFLOW : nfd_pkg::K_RECORD;
                word.from_set  = cur_x[15:0];
                word.accepting = |(r_cur & r_acc);
                word.last      = 1'b1;
            end
            S_DONE: begin
                push      = 1'b1;
                word.kind = nfd_pkg::K_DONE;
                word.last = 1'b1;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    nfd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (word),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_cfg.valid) begin
            r_start <= i_cfg.data;
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLEAR;
            r_clr    <= '0;
            r_acc    <= '0;
            r_head   <= '0;
            r_dcount <= '0;
            r_pend   <= 1'b0;
        end else begin
            case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == C_TD - 1'b1) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (nfd_pkg::t_op'(i_in.operation))
                            nfd_pkg::OP_LOAD: begin
                                r_laddr <= {fs_i, lt_i};
                                r_ts    <= ts_i;
                                if (edge_ok) begin
                                    r_st <= S_LOAD_WR;
                                end
                            end
                            nfd_pkg::OP_MARK: begin
                                if (mark_ok) begin
                                    r_acc[ti_i] <= 1'b1;
                                end
                            end
                            nfd_pkg::OP_BEGIN: begin
                                r_head   <= '0;
                                r_dcount <= start_ok ? DW'(1) : '0;
                            end
                            default: begin
                                if (r_head >= r_dcount) begin
                                    r_st <= S_DONE;
                                end else begin
                                    r_head <= r_head + 1'b1;
                                    r_st   <= S_CUR;
                                end
                            end
                        endcase
                    end
                end
                S_LOAD_WR: begin
                    r_st <= S_IDLE;
                end
                S_CUR: begin
                    r_cur  <= dm_q;
                    r_let  <= '0;
                    r_si   <= '0;
                    r_tgt  <= '0;
                    r_pend <= 1'b0;
                    r_full <= 1'b0;
                    r_st   <= S_ACC;
                end
                S_ACC: begin
                    // gather the union of member targets for this letter
                    if (r_pend && r_pmem) begin
                        r_tgt <= r_tgt | tm_q;
                    end
                    if (r_si != C_NS) begin
                        r_pmem <= r_cur[r_si[SB-1:0]];
                        r_si   <= r_si + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_st <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_tgt != '0) begin
                        r_st <= S_EDGE;
                    end else if (r_let == C_LAST) begin
                        r_st <= S_REC;
                    end else begin
                        r_let <= r_let + 1'b1;
                        r_si  <= '0;
                        r_st  <= S_ACC;
                    end
                end
                S_EDGE: begin
                    if (out_free) begin
                        r_sidx  <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_st    <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    // scan the discovered list for the target set
                    if (r_pend && dm_q == r_tgt) begin
                        r_found <= 1'b1;
                    end
                    if (r_sidx < r_dcount) begin
                        r_sidx <= r_sidx + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_st <= S_APPEND;
                        end
                    end
                end
                S_APPEND: begin
                    if (append) begin
                        r_dcount <= r_dcount + 1'b1;
                    end else if (!r_found) begin
                        r_full <= 1'b1;
                    end
                    r_tgt <= '0;
                    if (r_let == C_LAST) begin
                        r_st <= S_REC;
                    end else begin
                        r_let <= r_let + 1'b1;
                        r_si  <= '0;
                        r_st  <= S_ACC;
                    end
                end
                S_REC, S_DONE: begin
                    if (out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcount <= C_DFA)
        else $error("discovered count beyond table size");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_dcount)
        else $error("queue head passed discovered count");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        append |=> (r_dcount != '0) && (r_dcount == $past(r_dcount) + 1'b1))
        else $error("append did not grow the list");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == nfd_pkg::K_DONE) |-> o_out.last)
        else $error("done word without last");

endmodule

`default_nettype wire

>>> verif/nfd_scoreboard.sv
// scoreboard of the subset construction core: predicts result words from input words
// keeps its own nfa tables, discovered list and start register; depends on nfd_pkg
`timescale 1ns / 1ps

class nfd_scoreboard;
    localparam int NS = nfd_pkg::NFA_STATES_DEF;
    localparam int NA = nfd_pkg::ALPHABET_DEF;
    localparam int ND = nfd_pkg::DFA_STATES_DEF;

    logic [15:0] trans_tbl [NS*NA];
    logic [15:0] accept_bits;
    logic [15:0] found_sets [ND];
    int unsigned head_idx;
    int unsigned found_cnt;
    logic [3:0]  start_reg;
    nfd_pkg::t_result pending_words [$];
    int unsigned bad_cnt;

    function new();
        foreach (trans_tbl[i]) trans_tbl[i] = '0;
        accept_bits = '0;
        head_idx = 0;
        found_cnt = 0;
        start_reg = '0;
        bad_cnt = 0;
    endfunction

    function void set_start(logic [3:0] s);
        start_reg = s;
    endfunction

    function bit is_found(logic [15:0] s);
        for (int i = 0; i < found_cnt; i++)
            if (found_sets[i] == s) return 1;
        return 0;
    endfunction

    function void push_word(nfd_pkg::t_kind k, logic [15:0] f, logic [4:0] l,
                            logic [15:0] t, logic a, logic lst);
        nfd_pkg::t_result w;
        w.kind = k; w.from_set = f; w.edge_letter = l;
        w.to_set = t; w.accepting = a; w.last = lst;
        pending_words = {pending_words, w};
    endfunction

    // note one accepted input word
    function void note_input(nfd_pkg::t_op op, logic [3:0] fs, logic [3:0] ts,
                             logic [4:0] lt, logic [3:0] ti);
        logic [15:0] cur, tgt;
        bit full;
        case (op)
            nfd_pkg::OP_LOAD: trans_tbl[fs*NA+lt] |= 16'(1) << ts;
            nfd_pkg::OP_MARK: accept_bits |= 16'(1) << ti;
            nfd_pkg::OP_BEGIN: begin
                head_idx = 0;
                found_sets[0] = 16'(1) << start_reg;
                found_cnt = 1;
            end
            default: begin
                if (head_idx >= found_cnt) begin
                    push_word(nfd_pkg::K_DONE, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    cur = found_sets[head_idx];
                    head_idx++;
                    full = 0;
                    for (int l = 0; l < NA; l++) begin
                        tgt = '0;
                        for (int s = 0; s < NS; s++)
                            if (cur[s]) tgt |= trans_tbl[s*NA+l];
                        if (tgt != '0) begin
                            push_word(nfd_pkg::K_EDGE, cur, 5'(l), tgt, 1'b0, 1'b0);
                            if (!is_found(tgt)) begin
                                if (found_cnt < ND) found_sets[found_cnt++] = tgt;
                                else full = 1;
                            end
                        end
                    end
                    push_word(full ? nfd_pkg::K_OVERFLOW : nfd_pkg::K_RECORD, cur, '0, '0,
                              |(cur & accept_bits), 1'b1);
                end
            end
        endcase
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_result(nfd_pkg::t_result got);
        nfd_pkg::t_result exp_w;
        if (pending_words.size() == 0) begin
            bad_cnt++;
            if (bad_cnt <= 10) $display("unexpected word %h", got);
            return;
        end
        exp_w = pending_words.pop_front();
        if (got !== exp_w) begin
            bad_cnt++;
            if (bad_cnt <= 10)
                $display("word mismatch: expected %h actual %h", exp_w, got);
        end
    endfunction
endclass

>>> verif/nfa_to_dfa_subset_construction_core_test.sv
// testbench top of the subset construction core: directed and random words,
// random idling on both channels; depends on nfd_pkg, nfd_ifs, nfd_scoreboard and the core
`timescale 1ns / 1ps

module nfa_to_dfa_subset_construction_core_test;

    localparam int WATCH_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    nfd_in_if  in_ch();
    nfd_out_if out_ch();
    nfd_cfg_if cfg_ch();

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int idle_cycles = 0;
    bit timed_out = 0;
    nfd_scoreboard sb = new();

    nfa_to_dfa_subset_construction_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0; in_ch.operation = 0; in_ch.from_state = 0;
        in_ch.to_state = 0; in_ch.letter = 0; in_ch.terminal_index = 0;
        out_ch.ready = 0;
        cfg_ch.valid = 0; cfg_ch.data = 0;
    end

    // result side: random stall, check on accept
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({nfd_pkg::t_kind'(out_ch.kind), out_ch.from_set,
                             out_ch.edge_letter, out_ch.to_set, out_ch.accepting,
                             out_ch.last});
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog on cycles with no word moved
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays up after an accept until the next word or an idle cycle
    task automatic send_word(nfd_pkg::t_op op, logic [3:0] fs, logic [3:0] ts,
                             logic [4:0] lt, logic [3:0] ti);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1; in_ch.operation <= op; in_ch.from_state <= fs;
        in_ch.to_state <= ts; in_ch.letter <= lt; in_ch.terminal_index <= ti;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(op, fs, ts, lt, ti);
    endtask

    // wait for all predictions to drain, then for the tail of the last word
    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic write_start(logic [3:0] s);
        drain();
        cfg_ch.valid <= 1; cfg_ch.data <= s;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_start(s);
        cfg_ch.valid <= 0;
    endtask

    // random nfa then a construction run of n_steps steps with random content
    task automatic random_build(int n_edges, int n_steps, int max_state, int max_let);
        repeat (n_edges)
            send_word(nfd_pkg::OP_LOAD, 4'($urandom_range(max_state)),
                      4'($urandom_range(max_state)), 5'($urandom_range(max_let)),
                      4'($urandom));
        repeat (2) send_word(nfd_pkg::OP_MARK, 4'($urandom), 4'($urandom), 5'($urandom),
                             4'($urandom_range(max_state)));
        send_word(nfd_pkg::OP_BEGIN, 4'($urandom), 4'($urandom), 5'($urandom),
                  4'($urandom));
        repeat (n_steps)
            send_word(nfd_pkg::OP_STEP, 4'($urandom), 4'($urandom), 5'($urandom),
                      4'($urandom));
    endtask

    initial begin
        int phase_idle [4] = '{0, 67, 0, 11};
        int phase_stall [4] = '{0, 0, 67, 11};
        logic [3:0] starts [4] = '{4'd0, 4'd15, 4'd7, 4'd3};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: step before begin, extremes, marks, a start change
        send_word(nfd_pkg::OP_STEP, 4'd0, 4'd0, 5'd0, 4'd0);
        send_word(nfd_pkg::OP_LOAD, 4'd0, 4'd15, 5'd31, 4'd0);
        send_word(nfd_pkg::OP_LOAD, 4'd0, 4'd15, 5'd31, 4'd0);
        send_word(nfd_pkg::OP_LOAD, 4'd15, 4'd0, 5'd0, 4'd15);
        send_word(nfd_pkg::OP_LOAD, 4'd0, 4'd0, 5'd0, 4'd0);
        send_word(nfd_pkg::OP_LOAD, 4'd15, 4'd15, 5'd31, 4'd0);
        send_word(nfd_pkg::OP_MARK, 4'd0, 4'd0, 5'd0, 4'd15);
        send_word(nfd_pkg::OP_BEGIN, 4'd0, 4'd0, 5'd0, 4'd0);
        repeat (3) send_word(nfd_pkg::OP_STEP, 4'd0, 4'd0, 5'd0, 4'd0);
        send_word(nfd_pkg::OP_LOAD, 4'd5, 4'd9, 5'd16, 4'd0);
        send_word(nfd_pkg::OP_MARK, 4'd0, 4'd0, 5'd0, 4'd0);
        repeat (4) send_word(nfd_pkg::OP_STEP, 4'd15, 4'd15, 5'd31, 4'd15);
        write_start(4'd5);
        send_word(nfd_pkg::OP_BEGIN, 4'd0, 4'd0, 5'd0, 4'd0);
        repeat (3) send_word(nfd_pkg::OP_STEP, 4'd0, 4'd0, 5'd0, 4'd0);

        // random phases, each with its own start register
        for (int p = 0; p < 4; p++) begin
            write_start(starts[p]);
            src_idle_pct = phase_idle[p];
            snk_stall_pct = phase_stall[p];
            random_build(20, 12, 15, 31);
            random_build(12, 10, 3, 3);
            repeat (8) send_word(nfd_pkg::t_op'($urandom_range(3)), 4'($urandom),
                                 4'($urandom), 5'($urandom), 4'($urandom));
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
        drain();
        if (sb.bad_cnt == 0 && sb.pending_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> files.f
src/nfd_pkg.sv
src/nfd_ifs.sv
src/nfd_out_stage.sv
src/nfa_to_dfa_subset_construction_core.sv
verif/nfd_scoreboard.sv
verif/nfa_to_dfa_subset_construction_core_test.sv
